// ===== hw/rtl/dtlc_pkg.sv =====
// dtlc_pkg: shared types, codes and constants of the decimal token list checker
// no dependencies; used by dtlc_core, dtlc_rfifo and decimal_token_list_checker
package dtlc_pkg;

	// default limit on significant digits in one token
	localparam int MAX_DIGITS_DEF = 5;

	// fixed field widths
	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 17;
	localparam int KIND_W  = 2;
	localparam int CODE_W  = 3;
	localparam int SEEN_W  = 17;

	localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

	// character codes
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	// result queue depth, room for two results per word plus drain slack
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_COUNT   = 2'd0,
		KIND_NUMBER  = 2'd1,
		KIND_VERDICT = 2'd2
	} item_kind_t;

	typedef enum logic [CODE_W-1:0] {
		ERR_OK     = 3'd0,
		ERR_CHAR   = 3'd1,
		ERR_DIGITS = 3'd2,
		ERR_COUNT  = 3'd3,
		ERR_RANGE  = 3'd4
	} err_code_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		item_kind_t         kind;
		err_code_t          code;
		logic               last;
	} result_t;

	// bits needed for the largest token of the given number of digits
	function automatic int acc_width(input int digits);
		longint v;
		int     w;
		v = 1;
		w = 0;
		for (int i = 0; i < digits; i++) begin
			v = v * 10;
		end
		v = v - 1;
		for (int i = 0; i < 40; i++) begin
			if ((v >> i) != 0) begin
				w = i + 1;
			end
		end
		return w;
	endfunction

endpackage

// ===== hw/rtl/decimal_token_list_checker.sv =====
// decimal_token_list_checker: parses a line of decimal tokens and checks it
// uses the character channel word by word; results leave on the result channel.
// Every result is a word with token_value, item_kind, error_code and last_of_run.
// The first token of a line is the count N, later ones are module numbers; at
// end of line a verdict word follows. Bad characters and over-long tokens are
// reported at once and the rest of the line is dropped.
// A result word is valid the cycle after its character word is taken when the
// result queue is empty; words already queued go out first. One character word
// is taken per cycle while char_ready is high; the result channel gives one word
// per cycle while result_ready is high, so a character that causes two results
// (token plus verdict) leaves an extra word in the four-entry result queue,
// which absorbs it unless such characters keep coming back to back.
// char_ready drops while fewer than two queue slots are free; a stalled
// receiver therefore backs up the character side after two or three words that
// cause results; digits and repeated spaces never fill the queue.
// Reset clears the line state and empties the queue; nothing is pending after it.
// Depends on dtlc_pkg, dtlc_core and dtlc_rfifo.
module decimal_token_list_checker #(
	parameter int MAX_DIGITS = dtlc_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	output logic                          char_ready,
	input  logic [dtlc_pkg::CHAR_W-1:0]   char_code,
	input  logic                          end_of_line,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [dtlc_pkg::VALUE_W-1:0]  token_value,
	output logic [dtlc_pkg::KIND_W-1:0]   item_kind,
	output logic [dtlc_pkg::CODE_W-1:0]   error_code,
	output logic                          last_of_run
);

	dtlc_pkg::result_t res0, res1, rd;
	logic [1:0]        res_cnt, push_cnt;
	logic              take, space_ok;

	// word accepted when the queue can hold both possible results
	assign char_ready = space_ok;
	assign take       = char_valid && char_ready;
	assign push_cnt   = take ? res_cnt : 2'd0;

	dtlc_core #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.char_code  (char_code),
		.end_of_line(end_of_line),
		.res0       (res0),
		.res1       (res1),
		.res_cnt    (res_cnt)
	);

	dtlc_rfifo u_rfifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_cnt(push_cnt),
		.wr0     (res0),
		.wr1     (res1),
		.space_ok(space_ok),
		.rd_valid(result_valid),
		.rd_ready(result_ready),
		.rd      (rd)
	);

	// result fields out
	assign token_value = rd.value;
	assign item_kind   = rd.kind;
	assign error_code  = rd.code;
	assign last_of_run = rd.last;

endmodule

// ===== hw/rtl/dtlc_core.sv =====
// dtlc_core: line state registers and the per-character parse, close and verdict logic
// depends on dtlc_pkg; produces up to two results per accepted word
module dtlc_core #(
	parameter int MAX_DIGITS = dtlc_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [dtlc_pkg::CHAR_W-1:0]   char_code,
	input  logic                          end_of_line,
	output dtlc_pkg::result_t             res0,
	output dtlc_pkg::result_t             res1,
	output logic [1:0]                    res_cnt
);

	localparam int ACC_W = dtlc_pkg::acc_width(MAX_DIGITS);
	localparam int DC_W  = $clog2(MAX_DIGITS + 1);
	localparam int CMP_W = (ACC_W > dtlc_pkg::SEEN_W) ? ACC_W : dtlc_pkg::SEEN_W;

	logic [ACC_W-1:0]           acc_q, acc_a, acc_c, n_q, n_c;
	logic [DC_W-1:0]            dc_q, dc_a, dc_c;
	logic [dtlc_pkg::SEEN_W-1:0] seen_q, seen_c;
	logic                       have_q, have_c, rv_q, rv_c, disc_q, disc_a;
	logic                       is_space, is_digit, err_hit, close_tok, tok;
	dtlc_pkg::err_code_t        err_code, verdict;
	dtlc_pkg::item_kind_t       tok_kind;

	// character class; for digits the low nibble is the digit value
	assign is_space = (char_code == dtlc_pkg::CHAR_SPACE);
	assign is_digit = (char_code >= dtlc_pkg::CHAR_ZERO) && (char_code <= dtlc_pkg::CHAR_NINE);

	// digit accumulation and immediate errors
	always_comb begin
		acc_a    = acc_q;
		dc_a     = dc_q;
		disc_a   = disc_q;
		err_hit  = 1'b0;
		err_code = dtlc_pkg::ERR_OK;
		if (!disc_q) begin
			if (is_digit) begin
				// leading zeros are skipped
				if (!(dc_q == '0 && char_code[3:0] == 4'd0)) begin
					if (dc_q >= DC_W'(MAX_DIGITS)) begin
						err_hit  = 1'b1;
						err_code = dtlc_pkg::ERR_DIGITS;
						disc_a   = 1'b1;
					end else begin
						acc_a = ACC_W'({acc_q, 3'b000} + {2'b00, acc_q, 1'b0}
							+ (ACC_W + 3)'(char_code[3:0]));
						dc_a  = DC_W'(dc_q + 1'b1);
					end
				end
			end else if (!is_space) begin
				err_hit  = 1'b1;
				err_code = dtlc_pkg::ERR_CHAR;
				disc_a   = 1'b1;
			end
		end
	end

	// token close on a space or at end of line
	assign close_tok = !disc_a && (is_space || end_of_line);
	assign tok       = close_tok && (dc_a != '0);

	always_comb begin
		have_c   = have_q;
		n_c      = n_q;
		seen_c   = seen_q;
		rv_c     = rv_q;
		acc_c    = acc_a;
		dc_c     = dc_a;
		tok_kind = dtlc_pkg::KIND_COUNT;
		if (tok) begin
			if (!have_q) begin
				n_c    = acc_a;
				have_c = 1'b1;
			end else begin
				tok_kind = dtlc_pkg::KIND_NUMBER;
				if (seen_q != dtlc_pkg::SEEN_MAX) begin
					seen_c = dtlc_pkg::SEEN_W'(seen_q + 1'b1);
				end
				if (acc_a > n_q) begin
					rv_c = 1'b1;
				end
			end
			acc_c = '0;
			dc_c  = '0;
		end
	end

	// end of line verdict, in priority order
	always_comb begin
		if (!have_c || n_c == '0 || CMP_W'(seen_c) != CMP_W'(n_c)) begin
			verdict = dtlc_pkg::ERR_COUNT;
		end else if (rv_c) begin
			verdict = dtlc_pkg::ERR_RANGE;
		end else begin
			verdict = dtlc_pkg::ERR_OK;
		end
	end

	// result assembly: error alone, token alone, token then verdict, or verdict alone
	always_comb begin
		res0    = '0;
		res1    = '0;
		res_cnt = 2'd0;
		if (err_hit) begin
			res0.kind = dtlc_pkg::KIND_VERDICT;
			res0.code = err_code;
			res0.last = 1'b1;
			res_cnt   = 2'd1;
		end else if (tok) begin
			res0.value = dtlc_pkg::VALUE_W'(acc_a);
			res0.kind  = tok_kind;
			res0.code  = dtlc_pkg::ERR_OK;
			res0.last  = !end_of_line;
			res_cnt    = 2'd1;
			if (end_of_line) begin
				res1.kind = dtlc_pkg::KIND_VERDICT;
				res1.code = verdict;
				res1.last = 1'b1;
				res_cnt   = 2'd2;
			end
		end else if (end_of_line && !disc_a) begin
			res0.kind = dtlc_pkg::KIND_VERDICT;
			res0.code = verdict;
			res0.last = 1'b1;
			res_cnt   = 2'd1;
		end
	end

	// line state, cleared at every end of line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			dc_q   <= '0;
			have_q <= 1'b0;
			n_q    <= '0;
			seen_q <= '0;
			rv_q   <= 1'b0;
			disc_q <= 1'b0;
		end else if (take) begin
			if (end_of_line) begin
				acc_q  <= '0;
				dc_q   <= '0;
				have_q <= 1'b0;
				n_q    <= '0;
				seen_q <= '0;
				rv_q   <= 1'b0;
				disc_q <= 1'b0;
			end else begin
				acc_q  <= acc_c;
				dc_q   <= dc_c;
				have_q <= have_c;
				n_q    <= n_c;
				seen_q <= seen_c;
				rv_q   <= rv_c;
				disc_q <= disc_a;
			end
		end
	end

endmodule

// ===== hw/rtl/dtlc_rfifo.sv =====
// dtlc_rfifo: small result queue taking up to two results a cycle and giving one
// depends on dtlc_pkg for the result type and queue depth
module dtlc_rfifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  dtlc_pkg::result_t wr0,
	input  dtlc_pkg::result_t wr1,
	output logic              space_ok,
	output logic              rd_valid,
	input  logic              rd_ready,
	output dtlc_pkg::result_t rd
);

	dtlc_pkg::result_t                 entries_q [dtlc_pkg::RQ_DEPTH];
	logic [dtlc_pkg::RQ_PTR_W-1:0]     wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [dtlc_pkg::RQ_CNT_W-1:0]     count_q;
	logic                              pop;

	assign pop      = rd_valid && rd_ready;
	assign rd_valid = (count_q != '0);
	assign rd       = entries_q[rd_ptr_q];
	assign space_ok = (count_q <= dtlc_pkg::RQ_CNT_W'(dtlc_pkg::RQ_DEPTH - 2));
	assign wr_ptr1  = dtlc_pkg::RQ_PTR_W'(wr_ptr_q + 1'b1);

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			entries_q[wr_ptr_q] <= wr0;
		end
		if (push_cnt == 2'd2) begin
			entries_q[wr_ptr1] <= wr1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= dtlc_pkg::RQ_PTR_W'(wr_ptr_q + push_cnt);
			if (pop) begin
				rd_ptr_q <= dtlc_pkg::RQ_PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= dtlc_pkg::RQ_CNT_W'(count_q + push_cnt - pop);
		end
	end

endmodule

// ===== hw/rtl/dtlc_checker.sv =====
// dtlc_checker: port level assertions for decimal_token_list_checker
// depends on dtlc_pkg; attached to the top level by the bind at the end of this file
module dtlc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          char_valid,
	input logic                          char_ready,
	input logic [dtlc_pkg::CHAR_W-1:0]   char_code,
	input logic                          end_of_line,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [dtlc_pkg::VALUE_W-1:0]  token_value,
	input logic [dtlc_pkg::KIND_W-1:0]   item_kind,
	input logic [dtlc_pkg::CODE_W-1:0]   error_code,
	input logic                          last_of_run
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(token_value)
			&& $stable(item_kind) && $stable(error_code) && $stable(last_of_run))
		else $error("result word changed while stalled");

	// token words carry no error code
	a_tok_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind != dtlc_pkg::KIND_VERDICT |-> error_code == dtlc_pkg::ERR_OK)
		else $error("token word with error code");

	// verdict words carry a zero value and close the run
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind == dtlc_pkg::KIND_VERDICT |-> token_value == '0 && last_of_run)
		else $error("verdict word malformed");

	// a word that is neither last nor a verdict must be a count or number token
	a_tok_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind != dtlc_pkg::KIND_VERDICT && !last_of_run
			|-> item_kind == dtlc_pkg::KIND_COUNT || item_kind == dtlc_pkg::KIND_NUMBER)
		else $error("bad kind on non-final token");

	// no words out of an idle block straight after reset
	a_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !result_valid)
		else $error("result word right after reset");

endmodule

bind decimal_token_list_checker dtlc_checker u_dtlc_checker (.*);

// ===== tb/sv/dtlc_result_checker.sv =====
// dtlc_result_checker: watches both channels of the token list checker, predicts
// every result word from the accepted characters and compares them in order.
// depends on dtlc_pkg for widths, codes and the result word layout
`timescale 1ns / 1ps

module dtlc_result_checker #(
	parameter int MAX_DIGITS = dtlc_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	input  logic                          char_ready,
	input  logic [dtlc_pkg::CHAR_W-1:0]   char_code,
	input  logic                          end_of_line,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic [dtlc_pkg::VALUE_W-1:0]  token_value,
	input  logic [dtlc_pkg::KIND_W-1:0]   item_kind,
	input  logic [dtlc_pkg::CODE_W-1:0]   error_code,
	input  logic                          last_of_run,
	output int                            awaited_count,
	output int                            mismatch_count
);

	// line state of the parser as predicted
	int unsigned                  tok_acc;
	int unsigned                  digits;
	bit                           got_count;
	int unsigned                  count_n;
	logic [dtlc_pkg::SEEN_W-1:0]  numbers_seen;
	bit                           over_n;
	bit                           dropping;

	// words caused by the current character, and words still owed by the block
	dtlc_pkg::result_t run_words[$];
	dtlc_pkg::result_t awaited_words[$];

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t dtlc result check: %s", $time, what);
	endtask

	function automatic void reset_line();
		tok_acc = 0;
		digits = 0;
		got_count = 1'b0;
		count_n = 0;
		numbers_seen = '0;
		over_n = 1'b0;
		dropping = 1'b0;
	endfunction

	function automatic void emit(input int unsigned value, input dtlc_pkg::item_kind_t kind,
			input dtlc_pkg::err_code_t code);
		dtlc_pkg::result_t w;
		w.value = value[dtlc_pkg::VALUE_W-1:0];
		w.kind = kind;
		w.code = code;
		w.last = 1'b0;
		run_words.insert(run_words.size(), w);
	endfunction

	// a completed token is the count on first sight, a module number afterwards
	function automatic void finish_token();
		if (digits == 0) begin
			return;
		end
		if (!got_count) begin
			count_n = tok_acc;
			got_count = 1'b1;
			emit(tok_acc, dtlc_pkg::KIND_COUNT, dtlc_pkg::ERR_OK);
		end else begin
			if (numbers_seen != dtlc_pkg::SEEN_MAX) begin
				numbers_seen++;
			end
			if (tok_acc > count_n) begin
				over_n = 1'b1;
			end
			emit(tok_acc, dtlc_pkg::KIND_NUMBER, dtlc_pkg::ERR_OK);
		end
		tok_acc = 0;
		digits = 0;
	endfunction

	// expected words for one accepted character
	function automatic void parse_char(input logic [dtlc_pkg::CHAR_W-1:0] c, input logic eol);
		dtlc_pkg::err_code_t verdict;
		dtlc_pkg::result_t   w;
		run_words.delete();
		if (!dropping) begin
			if (c == dtlc_pkg::CHAR_SPACE) begin
				finish_token();
			end else if (c >= dtlc_pkg::CHAR_ZERO && c <= dtlc_pkg::CHAR_NINE) begin
				// leading zeros never count as significant digits
				if (!(digits == 0 && c == dtlc_pkg::CHAR_ZERO)) begin
					if (digits >= MAX_DIGITS) begin
						emit(0, dtlc_pkg::KIND_VERDICT, dtlc_pkg::ERR_DIGITS);
						dropping = 1'b1;
					end else begin
						tok_acc = tok_acc * 10 + (c - dtlc_pkg::CHAR_ZERO);
						digits++;
					end
				end
			end else begin
				emit(0, dtlc_pkg::KIND_VERDICT, dtlc_pkg::ERR_CHAR);
				dropping = 1'b1;
			end
		end
		// end of line closes the token and gives the verdict unless an error came
		if (eol) begin
			if (!dropping) begin
				finish_token();
				if (!got_count || count_n == 0 || numbers_seen != count_n) begin
					verdict = dtlc_pkg::ERR_COUNT;
				end else if (over_n) begin
					verdict = dtlc_pkg::ERR_RANGE;
				end else begin
					verdict = dtlc_pkg::ERR_OK;
				end
				emit(0, dtlc_pkg::KIND_VERDICT, verdict);
			end
			reset_line();
		end
		if (run_words.size() > 0) begin
			w = run_words.pop_back();
			w.last = 1'b1;
			run_words.insert(run_words.size(), w);
		end
		foreach (run_words[i]) begin
			awaited_words.insert(awaited_words.size(), run_words[i]);
		end
	endfunction

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin : watch_channels
		dtlc_pkg::result_t w;
		if (!arst_n) begin
			awaited_words.delete();
			reset_line();
		end else begin
			if (char_valid && char_ready) begin
				parse_char(char_code, end_of_line);
			end
			if (result_valid && result_ready) begin
				if (awaited_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word value %0d kind %0d code %0d last %0b",
						token_value, item_kind, error_code, last_of_run));
				end else begin
					w = awaited_words.pop_front();
					if (token_value !== w.value || item_kind !== w.kind
							|| error_code !== w.code || last_of_run !== w.last) begin
						report_mismatch($sformatf(
							"got value %0d kind %0d code %0d last %0b, want %0d %0d %0d %0b",
							token_value, item_kind, error_code, last_of_run,
							w.value, w.kind, w.code, w.last));
					end
				end
			end
		end
		awaited_count = awaited_words.size();
	end

endmodule

// ===== tb/sv/decimal_token_list_checker_tb.sv =====
// decimal_token_list_checker_tb: drives lines of characters into the block with
// random gaps and stalls; dtlc_result_checker predicts and compares the words.
// depends on dtlc_pkg, decimal_token_list_checker and dtlc_result_checker
`timescale 1ns / 1ps

module decimal_token_list_checker_tb;

	localparam int MAX_DIGITS   = dtlc_pkg::MAX_DIGITS_DEF;
	localparam int IDLE_PCT     = 21;
	localparam int CALM_FIRST   = 900;
	localparam int CALM_LAST    = 1500;
	localparam int HOLD_START   = 300;
	localparam int HOLD_LEN     = 80;
	localparam int RANDOM_CHARS = 1125;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [dtlc_pkg::CHAR_W-1:0] code;
		logic                        eol;
	} char_word_t;

	logic                         clk;
	logic                         arst_n;
	logic                         char_valid;
	logic                         char_ready;
	logic [dtlc_pkg::CHAR_W-1:0]  char_code;
	logic                         end_of_line;
	logic                         result_valid;
	logic                         result_ready;
	logic [dtlc_pkg::VALUE_W-1:0] token_value;
	logic [dtlc_pkg::KIND_W-1:0]  item_kind;
	logic [dtlc_pkg::CODE_W-1:0]  error_code;
	logic                         last_of_run;
	int                           awaited_count;
	int                           mismatch_count;
	int                           cycle = 0;

	char_word_t char_plan[$];

	decimal_token_list_checker #(.MAX_DIGITS(MAX_DIGITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_ready(char_ready),
		.char_code(char_code), .end_of_line(end_of_line),
		.result_valid(result_valid), .result_ready(result_ready),
		.token_value(token_value), .item_kind(item_kind),
		.error_code(error_code), .last_of_run(last_of_run)
	);

	dtlc_result_checker #(.MAX_DIGITS(MAX_DIGITS)) result_check (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_ready(char_ready),
		.char_code(char_code), .end_of_line(end_of_line),
		.result_valid(result_valid), .result_ready(result_ready),
		.token_value(token_value), .item_kind(item_kind),
		.error_code(error_code), .last_of_run(last_of_run),
		.awaited_count(awaited_count), .mismatch_count(mismatch_count)
	);

	// clock and cycle count
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
	end

	// watchdog
	initial begin
		while (cycle < CYCLE_LIMIT) @(posedge clk);
		$display("decimal_token_list_checker_tb: done, errors");
		$finish;
	end

	function automatic bit in_calm_window();
		return cycle >= CALM_FIRST && cycle < CALM_LAST;
	endfunction

	function automatic bit idle_now();
		return !in_calm_window() && $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	// receiver: random stalls, one long hold-off counted here
	initial begin : drive_result_ready
		int held;
		held = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (cycle >= HOLD_START && held < HOLD_LEN) begin
				result_ready <= 1'b0;
				held++;
			end else begin
				result_ready <= !idle_now();
			end
		end
	end

	// line building
	function automatic void push_char(input logic [dtlc_pkg::CHAR_W-1:0] c);
		char_word_t w;
		w.code = c;
		w.eol = 1'b0;
		char_plan.insert(char_plan.size(), w);
	endfunction

	function automatic void push_spaces(input int unsigned n);
		repeat (n) push_char(dtlc_pkg::CHAR_SPACE);
	endfunction

	function automatic void push_number(input int unsigned value, input int unsigned zeros);
		string s;
		repeat (zeros) push_char(dtlc_pkg::CHAR_ZERO);
		s = $sformatf("%0d", value);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i]);
		end
	endfunction

	function automatic void end_line();
		char_word_t w;
		w = char_plan.pop_back();
		w.eol = 1'b1;
		char_plan.insert(char_plan.size(), w);
	endfunction

	// hold valid low until every awaited word has come out
	task automatic wait_drained();
		char_valid <= 1'b0;
		do @(negedge clk); while (awaited_count != 0);
	endtask

	// one word on the character channel; called at a falling edge
	task automatic send_char(input char_word_t w);
		while (idle_now()) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_code <= w.code;
		end_of_line <= w.eol;
		do @(posedge clk); while (!char_ready);
		@(negedge clk);
	endtask

	task automatic send_plan(input int pause_at);
		for (int i = 0; i < char_plan.size(); i++) begin
			if (i == pause_at) begin
				wait_drained();
			end
			send_char(char_plan[i]);
		end
		char_plan.delete();
	endtask

	// stimulus and verdict
	initial begin
		int unsigned pick;
		int unsigned n;
		int unsigned tokens;
		int unsigned fault_at;
		int unsigned r;
		int unsigned v;
		bit          broken;
		logic [dtlc_pkg::CHAR_W-1:0] b;

		arst_n = 1'b0;
		char_valid = 1'b0;
		char_code = '0;
		end_of_line = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed lines
		push_char(dtlc_pkg::CHAR_SPACE);             // empty line
		end_line();
		push_number(2, 0);                           // good line, verdict with last token
		push_char(dtlc_pkg::CHAR_SPACE);
		push_number(1, 0);
		push_char(dtlc_pkg::CHAR_SPACE);
		push_number(2, 0);
		end_line();
		push_number(1, 0);                           // largest value, above the count
		push_char(dtlc_pkg::CHAR_SPACE);
		push_number(99999, 0);
		end_line();
		push_number(0, 1);                           // zeros only, no count at all
		push_char(dtlc_pkg::CHAR_SPACE);
		end_line();
		push_number(999999, 0);                      // over-long token on the last byte
		end_line();
		push_char(8'hFF);                            // bad byte on the last byte
		end_line();
		push_char(8'h00);                            // bad byte, rest ignored
		push_char(dtlc_pkg::CHAR_SPACE);
		end_line();
		send_plan(-1);
		wait_drained();

		// random lines, mostly well formed
		while (char_plan.size() < RANDOM_CHARS) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// noise
				repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
			end else if (pick < 12) begin
				// blank line
				push_spaces($urandom_range(1, 3));
			end else begin
				broken = pick < 27;
				if ($urandom_range(0, 19) == 0) begin
					n = $urandom_range(7, 99999);
					tokens = $urandom_range(0, 6);
				end else begin
					n = $urandom_range(1, 6);
					tokens = n;
					if ($urandom_range(0, 9) == 0) begin
						tokens = ($urandom_range(0, 1) || n == 0) ? n + 1 : n - 1;
					end
				end
				fault_at = $urandom_range(0, tokens);
				if ($urandom_range(0, 3) == 0) begin
					push_spaces($urandom_range(1, 2));
				end
				push_number(n, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
				for (int i = 0; i <= tokens; i++) begin
					// fault: a bad byte glued on, or an over-long token
					if (broken && i == fault_at) begin
						if ($urandom_range(0, 1)) begin
							do b = 8'($urandom_range(0, 255));
							while (b == dtlc_pkg::CHAR_SPACE
								|| (b >= dtlc_pkg::CHAR_ZERO && b <= dtlc_pkg::CHAR_NINE));
							push_char(b);
						end else begin
							push_char(dtlc_pkg::CHAR_SPACE);
							push_number($urandom_range(100000, 99999999), 0);
						end
					end
					if (i == tokens) begin
						break;
					end
					push_spaces(($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1);
					r = $urandom_range(0, 19);
					if (r == 0) begin
						v = $urandom_range(1, 99999);
					end else if (r == 1) begin
						v = 99999;
					end else if (r == 2) begin
						v = 0;
					end else begin
						v = $urandom_range(1, n);
					end
					push_number(v, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
				end
				if ($urandom_range(0, 2) == 0) begin
					push_spaces($urandom_range(1, 2));
				end
			end
			end_line();
		end
		send_plan(char_plan.size() / 2);

		// drain and settle
		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("decimal_token_list_checker_tb: done, clean");
		end else begin
			$display("decimal_token_list_checker_tb: done, errors");
		end
		$finish;
	end

endmodule
